// File: hdl/pnm_pkg.sv
// Package for the PNM raster decoder: payload structs, format codes and
// the queue entry passed from the byte classifier to the pixel unit.
// No dependencies.
`timescale 1ns / 1ps
package pnm_pkg;

    localparam int MaxWidth  = 4096;
    localparam int MaxHeight = 4096;
    localparam int DimW      = 13;
    localparam int PosW      = 12;
    localparam int AccW      = 17;
    localparam logic [AccW-1:0] AccMax = 17'h1FFFF;

    localparam logic [2:0] FMT_PBM_ASCII = 3'd0;
    localparam logic [2:0] FMT_PBM_BIN   = 3'd1;
    localparam logic [2:0] FMT_PGM_ASCII = 3'd2;
    localparam logic [2:0] FMT_PGM_BIN   = 3'd3;
    localparam logic [2:0] FMT_PPM_ASCII = 3'd4;
    localparam logic [2:0] FMT_PPM_BIN   = 3'd5;

    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_MAXVAL = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } pnm_in_t;

    typedef struct packed {
        logic [15:0]     gray_or_red;
        logic [15:0]     green;
        logic [15:0]     blue;
        logic [PosW-1:0] pixel_column;
        logic [PosW-1:0] pixel_row;
        logic            row_end;
        logic            image_end;
        logic            run_last;
        logic            sample_clipped;
    } pnm_out_t;

    typedef enum logic [2:0] {
        JOB_START = 3'b001,
        JOB_PBMA  = 3'b010,
        JOB_BITS  = 3'b100,
        JOB_NONE  = 3'b000,
        JOB_SAMP  = 3'b011
    } pnm_job_t;

    // One unit of work for the back end.
    typedef struct packed {
        pnm_job_t        job;
        logic [AccW-1:0] value;
    } pnm_work_t;

endpackage

// File: hdl/pnm_raster_decoder_core.sv
// PNM raster decoder top level: configuration registers and the
// classifier, queue and pixel unit. Depends on pnm_pkg and those modules.
// Each raster byte is classified; a PGM or PPM sample then goes through
// the radix-2 scaling divider (32 quotient steps), and a binary PBM byte
// gives one pixel per cycle, up to 8, while the output is not stalled. A
// two-entry queue lets bytes be taken while the pixel unit is busy.
`timescale 1ns / 1ps
module pnm_raster_decoder_core import pnm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  pnm_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output pnm_out_t    m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    logic [2:0]      fmt_reg;
    logic [15:0]     maxv_reg;
    logic [DimW-1:0] width_reg, height_reg;
    logic            fq_valid, fq_ready, qb_valid, qb_ready;
    pnm_work_t       fq_data, qb_data;
    logic            wide;

    assign cfg_ready = 1'b1;
    assign wide = maxv_reg > 16'd255;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_PBM_ASCII; maxv_reg <= 16'd255;
            width_reg <= 13'd1; height_reg <= 13'd1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FORMAT: fmt_reg    <= cfg_data[2:0];
                REG_MAXVAL: maxv_reg   <= cfg_data;
                REG_WIDTH:  width_reg  <= cfg_data[DimW-1:0];
                REG_HEIGHT: height_reg <= cfg_data[DimW-1:0];
                default: ;
            endcase
        end
    end

    pnm_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .fmt(fmt_reg), .wide,
        .w_valid(fq_valid), .w_ready(fq_ready), .w_data(fq_data)
    );

    pnm_queue u_queue (
        .aclk, .aresetn,
        .i_valid(fq_valid), .i_ready(fq_ready), .i_data(fq_data),
        .o_valid(qb_valid), .o_ready(qb_ready), .o_data(qb_data)
    );

    pnm_back u_back (
        .aclk, .aresetn,
        .w_valid(qb_valid), .w_ready(qb_ready), .w_data(qb_data),
        .fmt(fmt_reg), .maxv(maxv_reg), .width(width_reg), .height(height_reg),
        .m_valid, .m_ready, .m_data
    );
endmodule

// File: hdl/pnm_front.sv
// Byte classifier of the PNM raster decoder: digit runs, wide byte pairing.
// Depends on pnm_pkg.
`timescale 1ns / 1ps
module pnm_front import pnm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  pnm_in_t   s_data,
    input  logic [2:0]  fmt,
    input  logic        wide,
    output logic      w_valid,
    input  logic      w_ready,
    output pnm_work_t w_data
);
    logic [AccW-1:0] acc_reg, acc_next;
    logic            innum_reg, innum_next;
    logic [7:0]      hi_reg, hi_next;
    logic            phase_reg, phase_next;
    logic            take;
    logic [AccW+3:0] prod;
    logic            digit;

    assign s_ready = w_ready;
    assign take    = s_valid && s_ready;
    assign digit   = s_data.data_byte >= 8'h30 && s_data.data_byte <= 8'h39;
    assign prod    = {4'd0, acc_reg} * 21'd10 + {17'd0, s_data.data_byte[3:0]};

    always_comb begin
        acc_next   = acc_reg;
        innum_next = innum_reg;
        hi_next    = hi_reg;
        phase_next = phase_reg;
        w_data.job   = JOB_NONE;
        w_data.value = '0;
        if (s_data.cmd == CMD_START) begin
            acc_next = '0; innum_next = 1'b0; hi_next = '0; phase_next = 1'b0;
            w_data.job = JOB_START;
        end else if (fmt == FMT_PBM_ASCII || fmt == FMT_PGM_ASCII
                     || fmt == FMT_PPM_ASCII) begin
            if (digit) begin
                acc_next   = (prod > {4'd0, AccMax}) ? AccMax : prod[AccW-1:0];
                innum_next = 1'b1;
            end else if (innum_reg) begin
                acc_next   = '0;
                innum_next = 1'b0;
                w_data.job   = (fmt == FMT_PBM_ASCII) ? JOB_PBMA : JOB_SAMP;
                w_data.value = acc_reg;
            end
        end else if (fmt == FMT_PBM_BIN) begin
            w_data.job   = JOB_BITS;
            w_data.value = {9'd0, s_data.data_byte};
        end else if (fmt == FMT_PGM_BIN || fmt == FMT_PPM_BIN) begin
            if (wide && !phase_reg) begin
                hi_next = s_data.data_byte; phase_next = 1'b1;
            end else begin
                phase_next   = 1'b0;
                w_data.job   = JOB_SAMP;
                w_data.value = wide ? {1'b0, hi_reg, s_data.data_byte}
                                    : {9'd0, s_data.data_byte};
            end
        end
    end

    assign w_valid = s_valid && w_data.job != JOB_NONE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0; innum_reg <= 1'b0; hi_reg <= '0; phase_reg <= 1'b0;
        end else if (take) begin
            acc_reg <= acc_next; innum_reg <= innum_next;
            hi_reg <= hi_next; phase_reg <= phase_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        take && s_data.cmd == CMD_START |-> w_valid)
        else $error("start command not queued");
    assert property (@(posedge aclk) disable iff (!aresetn)
        take && digit && s_data.cmd == CMD_BYTE && fmt == FMT_PGM_ASCII |=> innum_reg)
        else $error("digit did not open a run");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !take |=> $stable(acc_reg) && $stable(phase_reg))
        else $error("state changed without an item");
endmodule

// File: hdl/pnm_queue.sv
// Two-entry queue between the classifier and the pixel unit.
// Depends on pnm_pkg.
`timescale 1ns / 1ps
module pnm_queue import pnm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      i_valid,
    output logic      i_ready,
    input  pnm_work_t i_data,
    output logic      o_valid,
    input  logic      o_ready,
    output pnm_work_t o_data
);
    pnm_work_t mem_reg [2];
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic      push, pop;

    assign i_ready = cnt_reg != 2'd2;
    assign o_valid = cnt_reg != 2'd0;
    assign o_data  = mem_reg[rp_reg];
    assign push    = i_valid && i_ready;
    assign pop     = o_valid && o_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= i_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd0 |-> wp_reg == rp_reg)
        else $error("empty pointers");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> wp_reg == rp_reg)
        else $error("full pointers");
endmodule

// File: hdl/pnm_back.sv
// Pixel unit of the PNM raster decoder: saturation, iterative scaling
// divider, PPM channel gathering, bit unpacking and position counting.
// Depends on pnm_pkg.
`timescale 1ns / 1ps
module pnm_back import pnm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        w_valid,
    output logic        w_ready,
    input  pnm_work_t   w_data,
    input  logic [2:0]  fmt,
    input  logic [15:0] maxv,
    input  logic [DimW-1:0] width,
    input  logic [DimW-1:0] height,
    output logic        m_valid,
    input  logic        m_ready,
    output pnm_out_t    m_data
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_BITS = 4'b0100,
        ST_OUT  = 4'b1000
    } st_t;

    st_t         st_reg;
    logic [1:0]  ch_reg;
    logic [15:0] red_reg, grn_reg;
    logic        hclip_reg;
    logic [PosW-1:0] col_reg, row_reg;
    logic        done_reg;
    logic [31:0] num_reg;
    logic [16:0] rem_reg;
    logic [31:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic        clip_reg;
    logic [7:0]  bits_reg;
    logic [3:0]  nbit_reg;
    logic        ovalid_reg, ovalid_next;
    pnm_out_t    out_reg;

    logic [15:0] m_eff;
    logic        wide;
    logic [DimW-1:0] w_eff, h_eff;
    logic        re, ie;
    logic [17:0] trial;
    logic [16:0] sat;
    logic        sclip;
    logic        out_free;
    logic        out_load;

    assign m_eff = (maxv == 16'd0) ? 16'd1 : maxv;
    assign wide  = m_eff > 16'd255;
    assign w_eff = (width == '0) ? 13'd1 : (width > 13'(MaxWidth)) ? 13'(MaxWidth) : width;
    assign h_eff = (height == '0) ? 13'd1 : (height > 13'(MaxHeight)) ? 13'(MaxHeight) : height;
    assign re = {1'b0, col_reg} + 13'd1 >= w_eff;
    assign ie = re && ({1'b0, row_reg} + 13'd1 >= h_eff);
    assign sclip = w_data.value > {1'b0, m_eff};
    assign sat   = sclip ? {1'b0, m_eff} : w_data.value;
    assign trial = {rem_reg, num_reg[31]} - {2'b0, m_eff};
    assign out_free = !ovalid_reg || m_ready;
    assign m_valid = ovalid_reg;
    assign m_data  = out_reg;
    assign w_ready = (st_reg == ST_IDLE) && out_free;

    assign out_load = out_free && (
        (st_reg == ST_IDLE && w_valid && w_data.job == JOB_PBMA && !done_reg)
        || (st_reg == ST_OUT && (!(fmt == FMT_PPM_ASCII || fmt == FMT_PPM_BIN)
                                 || ch_reg == 2'd2))
        || st_reg == ST_BITS);
    assign ovalid_next = out_load || (ovalid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else begin
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE; ch_reg <= '0; red_reg <= '0; grn_reg <= '0;
            hclip_reg <= 1'b0; col_reg <= '0; row_reg <= '0; done_reg <= 1'b0;
        end else begin
            unique case (st_reg)
                ST_IDLE: begin
                    if (w_valid && w_ready) begin
                        if (w_data.job == JOB_START) begin
                            ch_reg <= '0; red_reg <= '0; grn_reg <= '0; hclip_reg <= 1'b0;
                            col_reg <= '0; row_reg <= '0; done_reg <= 1'b0;
                        end else if (!done_reg) begin
                            if (w_data.job == JOB_PBMA) begin
                                logic [15:0] g;
                                g = (w_data.value == 17'd0) ? 16'h00FF :
                                    (w_data.value == 17'd1) ? 16'h0000 :
                                    {8'd0, w_data.value[7:0]};
                                out_reg <= '{g, g, g, col_reg, row_reg, re, ie, 1'b1, 1'b0};
                                col_reg <= re ? '0 : col_reg + 12'd1;
                                if (re) row_reg <= ie ? '0 : row_reg + 12'd1;
                                if (ie) done_reg <= 1'b1;
                            end else if (w_data.job == JOB_BITS) begin
                                bits_reg <= w_data.value[7:0];
                                nbit_reg <= '0;
                                st_reg   <= ST_BITS;
                            end else if (w_data.job == JOB_SAMP) begin
                                num_reg  <= (wide ? {16'd0, 16'hFFFF} : 32'd255) * {15'd0, sat};
                                rem_reg  <= '0; quo_reg <= '0; cnt_reg <= '0;
                                clip_reg <= sclip;
                                st_reg   <= ST_DIV;
                            end
                        end
                    end
                end
                ST_DIV: begin
                    if (!trial[17]) begin
                        rem_reg <= trial[16:0];
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[15:0], num_reg[31]};
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                    num_reg <= {num_reg[30:0], 1'b0};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31) st_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (fmt == FMT_PPM_ASCII || fmt == FMT_PPM_BIN) begin
                        if (ch_reg == 2'd0) begin
                            red_reg <= quo_reg[15:0]; hclip_reg <= clip_reg;
                            ch_reg <= 2'd1; st_reg <= ST_IDLE;
                        end else if (ch_reg == 2'd1) begin
                            grn_reg <= quo_reg[15:0]; hclip_reg <= hclip_reg | clip_reg;
                            ch_reg <= 2'd2; st_reg <= ST_IDLE;
                        end else if (out_free) begin
                            out_reg <= '{red_reg, grn_reg, quo_reg[15:0], col_reg, row_reg,
                                         re, ie, 1'b1, hclip_reg | clip_reg};
                            ch_reg <= '0; st_reg <= ST_IDLE;
                            col_reg <= re ? '0 : col_reg + 12'd1;
                            if (re) row_reg <= ie ? '0 : row_reg + 12'd1;
                            if (ie) done_reg <= 1'b1;
                        end
                    end else if (out_free) begin
                        out_reg <= '{quo_reg[15:0], 16'd0, 16'd0, col_reg, row_reg,
                                     re, ie, 1'b1, clip_reg};
                        st_reg <= ST_IDLE;
                        col_reg <= re ? '0 : col_reg + 12'd1;
                        if (re) row_reg <= ie ? '0 : row_reg + 12'd1;
                        if (ie) done_reg <= 1'b1;
                    end
                end
                ST_BITS: begin
                    if (out_free) begin
                        logic [15:0] g;
                        logic        lastb;
                        g = bits_reg[7] ? 16'h0000 : 16'h00FF;
                        lastb = re || nbit_reg == 4'd7;
                        out_reg <= '{g, g, g, col_reg, row_reg, re, ie, lastb, 1'b0};
                        bits_reg <= {bits_reg[6:0], 1'b0};
                        nbit_reg <= nbit_reg + 4'd1;
                        col_reg <= re ? '0 : col_reg + 12'd1;
                        if (re) row_reg <= ie ? '0 : row_reg + 12'd1;
                        if (ie) done_reg <= 1'b1;
                        if (lastb) st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.image_end |-> m_data.row_end)
        else $error("image end without row end");
    assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_DIV |-> cnt_reg <= 6'd31)
        else $error("divider overrun");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while waiting");
endmodule
